// ===== hw/rtl/i2cebam_pkg.sv =====
package i2cebam_pkg;

	localparam int unsigned HalfW  = 16;
	localparam int unsigned CycleW = 24;
	localparam int unsigned PollW  = 8;
	localparam int unsigned TickW  = 24;
	localparam int unsigned CfgW   = 24;
	localparam int unsigned CfgIdxW = 2;

	localparam logic [CfgIdxW-1:0] CFG_HALF_PERIOD = 2'd0;
	localparam logic [CfgIdxW-1:0] CFG_WRITE_CYCLE = 2'd1;
	localparam logic [CfgIdxW-1:0] CFG_POLL_LIMIT  = 2'd2;

	localparam logic [HalfW-1:0]  HALF_PERIOD_RESET = 16'd50;
	localparam logic [CycleW-1:0] WRITE_CYCLE_RESET = 24'd250000;
	localparam logic [PollW-1:0]  POLL_LIMIT_RESET  = 8'd255;

	localparam logic [1:0] MODE_IDLE  = 2'd0;
	localparam logic [1:0] MODE_WRITE = 2'd1;
	localparam logic [1:0] MODE_READ  = 2'd2;

	localparam logic [7:0] CTRL_WRITE_BYTE = 8'hA0;
	localparam logic [7:0] CTRL_READ_BYTE  = 8'hA1;

	typedef enum logic [17:0] {
		PH_IDLE  = 18'h00001,
		PH_START = 18'h00002,
		PH_BLOW  = 18'h00004,
		PH_BSET  = 18'h00008,
		PH_BHIGH = 18'h00010,
		PH_BTAIL = 18'h00020,
		PH_BREL  = 18'h00040,
		PH_AHIGH = 18'h00080,
		PH_APOLL = 18'h00100,
		PH_ALOW  = 18'h00200,
		PH_RLOW  = 18'h00400,
		PH_RPRE  = 18'h00800,
		PH_RHIGH = 18'h01000,
		PH_RTAIL = 18'h02000,
		PH_NHIGH = 18'h04000,
		PH_NLOW  = 18'h08000,
		PH_STOP  = 18'h10000,
		PH_WAIT  = 18'h20000
	} phase_t;

	typedef struct packed {
		phase_t           phase;
		logic [3:0]       bit_count;
		logic [7:0]       shift_byte;
		logic [2:0]       byte_index;
		logic [TickW-1:0] tick_count;
		logic [PollW-1:0] poll_count;
		logic [7:0]       data_latch;
		logic             is_read;
		logic             scl;
		logic             sda;
	} state_t;

	typedef struct packed {
		logic       scl_level;
		logic       sda_release;
		logic       busy_res;
		logic       done_res;
		logic [7:0] read_byte;
	} result_t;

	typedef struct packed {
		logic [HalfW-1:0]  half_period_ticks;
		logic [CycleW-1:0] write_cycle_ticks;
		logic [PollW-1:0]  ack_poll_limit;
	} config_t;

endpackage

// ===== hw/rtl/i2c_eeprom_byte_access_master_core.sv =====
// A request is taken into the input register, then its result into the result register.
// Throughput: one request per cycle; the pin sequencer advances once per request.
// The input register and the result register each stall only on a held result.
// Asynchronous active-low reset returns the sequencer to idle with both pins
// released and loads the three configuration registers with their defaults.
module i2c_eeprom_byte_access_master_core #(
	parameter int unsigned ADDRESS_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write_en,
	input  logic [1:0]  cfg_index,
	input  logic [23:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  mode,
	input  logic [15:0] mem_address,
	input  logic [7:0]  write_byte,
	input  logic        sda_level,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        scl_level,
	output logic        sda_release,
	output logic        busy_res,
	output logic        done_res,
	output logic [7:0]  read_byte
);

	i2cebam_pkg::config_t  cfg_q;
	i2cebam_pkg::state_t   state_q;
	i2cebam_pkg::state_t   state_nxt;
	logic [ADDRESS_BITS-1:0] address_q;
	logic [ADDRESS_BITS-1:0] address_nxt;
	i2cebam_pkg::result_t  res_nxt;
	i2cebam_pkg::result_t  res_q;
	logic                  out_valid_q;

	logic        valid_s1;
	logic [1:0]  mode_s1;
	logic [15:0] mem_address_s1;
	logic [7:0]  write_byte_s1;
	logic        sda_level_s1;
	logic        advance;

	assign advance = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.half_period_ticks <= i2cebam_pkg::HALF_PERIOD_RESET;
			cfg_q.write_cycle_ticks <= i2cebam_pkg::WRITE_CYCLE_RESET;
			cfg_q.ack_poll_limit <= i2cebam_pkg::POLL_LIMIT_RESET;
		end else if (cfg_write_en) begin
			case (cfg_index)
				i2cebam_pkg::CFG_HALF_PERIOD: begin
					cfg_q.half_period_ticks <= cfg_data[i2cebam_pkg::HalfW-1:0];
				end
				i2cebam_pkg::CFG_WRITE_CYCLE: begin
					cfg_q.write_cycle_ticks <= cfg_data[i2cebam_pkg::CycleW-1:0];
				end
				i2cebam_pkg::CFG_POLL_LIMIT: begin
					cfg_q.ack_poll_limit <= cfg_data[i2cebam_pkg::PollW-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			mode_s1 <= mode;
			mem_address_s1 <= mem_address;
			write_byte_s1 <= write_byte;
			sda_level_s1 <= sda_level;
		end
	end

	i2cebam_step #(
		.ADDRESS_BITS(ADDRESS_BITS)
	) u_step (
		.cur(state_q),
		.cur_address(address_q),
		.cfg(cfg_q),
		.mode(mode_s1),
		.mem_address(mem_address_s1),
		.write_byte(write_byte_s1),
		.sda_level(sda_level_s1),
		.nxt(state_nxt),
		.nxt_address(address_nxt),
		.res(res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase <= i2cebam_pkg::PH_IDLE;
			state_q.bit_count <= '0;
			state_q.shift_byte <= '0;
			state_q.byte_index <= '0;
			state_q.tick_count <= '0;
			state_q.poll_count <= '0;
			state_q.data_latch <= '0;
			state_q.is_read <= 1'b0;
			state_q.scl <= 1'b1;
			state_q.sda <= 1'b1;
			address_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				state_q <= state_nxt;
				address_q <= address_nxt;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_nxt;
		end
	end

	assign out_valid = out_valid_q;
	assign scl_level = res_q.scl_level;
	assign sda_release = res_q.sda_release;
	assign busy_res = res_q.busy_res;
	assign done_res = res_q.done_res;
	assign read_byte = res_q.read_byte;

endmodule

// ===== hw/rtl/i2cebam_step.sv =====
module i2cebam_step #(
	parameter int unsigned ADDRESS_BITS = 16
) (
	input  i2cebam_pkg::state_t    cur,
	input  logic [ADDRESS_BITS-1:0] cur_address,
	input  i2cebam_pkg::config_t   cfg,
	input  logic [1:0]              mode,
	input  logic [15:0]             mem_address,
	input  logic [7:0]              write_byte,
	input  logic                    sda_level,
	output i2cebam_pkg::state_t    nxt,
	output logic [ADDRESS_BITS-1:0] nxt_address,
	output i2cebam_pkg::result_t   res
);

	logic [i2cebam_pkg::TickW-1:0] half_ticks;
	logic [i2cebam_pkg::TickW-1:0] tick_dec;
	logic [15:0]                   addr_wide;
	logic [7:0]                    idx_byte;
	logic [2:0]                    idx_next;
	logic                          ent_en;
	i2cebam_pkg::phase_t           ent;
	logic                          done;

	assign half_ticks = (cfg.half_period_ticks == '0) ? i2cebam_pkg::TickW'(1) :
		i2cebam_pkg::TickW'(cfg.half_period_ticks);
	assign tick_dec = (cur.tick_count != '0) ? cur.tick_count - 1'b1 : cur.tick_count;
	assign addr_wide = 16'(cur_address);
	assign idx_next = (cur.phase == i2cebam_pkg::PH_ALOW) ? cur.byte_index + 3'd1 :
		cur.byte_index;

	always_comb begin
		case (idx_next)
			3'd0: idx_byte = i2cebam_pkg::CTRL_WRITE_BYTE;
			3'd1: idx_byte = addr_wide[15:8];
			3'd2: idx_byte = addr_wide[7:0];
			default: idx_byte = cur.is_read ? i2cebam_pkg::CTRL_READ_BYTE : cur.data_latch;
		endcase
	end

	always_comb begin
		nxt = cur;
		nxt_address = cur_address;
		done = 1'b0;
		ent_en = 1'b0;
		ent = i2cebam_pkg::PH_IDLE;

		if (cur.phase == i2cebam_pkg::PH_IDLE) begin
			if (mode == i2cebam_pkg::MODE_WRITE || mode == i2cebam_pkg::MODE_READ) begin
				nxt_address = mem_address[ADDRESS_BITS-1:0];
				nxt.data_latch = write_byte;
				nxt.is_read = (mode == i2cebam_pkg::MODE_READ);
				nxt.byte_index = 3'd0;
				nxt.bit_count = 4'd0;
				nxt.shift_byte = 8'd0;
				ent_en = 1'b1;
				ent = i2cebam_pkg::PH_START;
			end
		end else if (cur.phase == i2cebam_pkg::PH_APOLL) begin
			if (sda_level && cur.poll_count < cfg.ack_poll_limit) begin
				nxt.poll_count = cur.poll_count + 1'b1;
			end else begin
				ent_en = 1'b1;
				ent = i2cebam_pkg::PH_ALOW;
			end
		end else begin
			nxt.tick_count = tick_dec;
			if (tick_dec == '0) begin
				ent_en = 1'b1;
				case (cur.phase)
					i2cebam_pkg::PH_START: begin
						nxt.shift_byte = idx_byte;
						nxt.bit_count = 4'd0;
						nxt.sda = 1'b0;
						ent = i2cebam_pkg::PH_BLOW;
					end
					i2cebam_pkg::PH_BLOW: ent = i2cebam_pkg::PH_BSET;
					i2cebam_pkg::PH_BSET: ent = i2cebam_pkg::PH_BHIGH;
					i2cebam_pkg::PH_BHIGH: begin
						nxt.bit_count = cur.bit_count + 4'd1;
						ent = (nxt.bit_count < 4'd8) ? i2cebam_pkg::PH_BLOW :
							i2cebam_pkg::PH_BTAIL;
					end
					i2cebam_pkg::PH_BTAIL: ent = i2cebam_pkg::PH_BREL;
					i2cebam_pkg::PH_BREL: ent = i2cebam_pkg::PH_AHIGH;
					i2cebam_pkg::PH_AHIGH: ent = i2cebam_pkg::PH_APOLL;
					i2cebam_pkg::PH_ALOW: begin
						nxt.byte_index = idx_next;
						if (cur.is_read && idx_next == 3'd3) begin
							ent = i2cebam_pkg::PH_START;
						end else if (cur.is_read && idx_next >= 3'd4) begin
							nxt.bit_count = 4'd0;
							nxt.shift_byte = 8'd0;
							ent = i2cebam_pkg::PH_RLOW;
						end else if (!cur.is_read && idx_next >= 3'd4) begin
							ent = i2cebam_pkg::PH_STOP;
						end else begin
							nxt.shift_byte = idx_byte;
							nxt.bit_count = 4'd0;
							ent = i2cebam_pkg::PH_BLOW;
						end
					end
					i2cebam_pkg::PH_RLOW: ent = i2cebam_pkg::PH_RPRE;
					i2cebam_pkg::PH_RPRE: ent = i2cebam_pkg::PH_RHIGH;
					i2cebam_pkg::PH_RHIGH: begin
						nxt.shift_byte = {cur.shift_byte[6:0], sda_level};
						nxt.bit_count = cur.bit_count + 4'd1;
						ent = (nxt.bit_count < 4'd8) ? i2cebam_pkg::PH_RPRE :
							i2cebam_pkg::PH_RTAIL;
					end
					i2cebam_pkg::PH_RTAIL: ent = i2cebam_pkg::PH_NHIGH;
					i2cebam_pkg::PH_NHIGH: ent = i2cebam_pkg::PH_NLOW;
					i2cebam_pkg::PH_NLOW: ent = i2cebam_pkg::PH_STOP;
					i2cebam_pkg::PH_STOP: begin
						ent = cur.is_read ? i2cebam_pkg::PH_IDLE : i2cebam_pkg::PH_WAIT;
					end
					default: ent = i2cebam_pkg::PH_IDLE;
				endcase
			end
		end

		if (ent_en) begin
			nxt.phase = ent;
			nxt.tick_count = half_ticks;
			case (ent)
				i2cebam_pkg::PH_START: begin
					nxt.scl = 1'b1;
					nxt.sda = 1'b1;
				end
				i2cebam_pkg::PH_BLOW: nxt.scl = 1'b0;
				i2cebam_pkg::PH_BSET: nxt.sda = nxt.shift_byte[3'd7 - nxt.bit_count[2:0]];
				i2cebam_pkg::PH_BHIGH: nxt.scl = 1'b1;
				i2cebam_pkg::PH_BTAIL: nxt.scl = 1'b0;
				i2cebam_pkg::PH_BREL: nxt.sda = 1'b1;
				i2cebam_pkg::PH_AHIGH: nxt.scl = 1'b1;
				i2cebam_pkg::PH_APOLL: begin
					nxt.tick_count = '0;
					if (sda_level && cfg.ack_poll_limit != '0) begin
						nxt.poll_count = i2cebam_pkg::PollW'(1);
					end else begin
						nxt.poll_count = '0;
						nxt.phase = i2cebam_pkg::PH_ALOW;
						nxt.tick_count = half_ticks;
						nxt.scl = 1'b0;
					end
				end
				i2cebam_pkg::PH_ALOW: nxt.scl = 1'b0;
				i2cebam_pkg::PH_RLOW: nxt.scl = 1'b0;
				i2cebam_pkg::PH_RPRE: begin
					nxt.scl = 1'b0;
					nxt.sda = 1'b1;
				end
				i2cebam_pkg::PH_RHIGH: nxt.scl = 1'b1;
				i2cebam_pkg::PH_RTAIL: begin
					nxt.scl = 1'b0;
					nxt.sda = 1'b1;
				end
				i2cebam_pkg::PH_NHIGH: begin
					nxt.scl = 1'b1;
					nxt.sda = 1'b1;
				end
				i2cebam_pkg::PH_NLOW: nxt.scl = 1'b0;
				i2cebam_pkg::PH_STOP: begin
					nxt.scl = 1'b1;
					nxt.sda = 1'b0;
				end
				i2cebam_pkg::PH_WAIT: begin
					nxt.scl = 1'b1;
					nxt.sda = 1'b1;
					nxt.tick_count = cfg.write_cycle_ticks;
					if (cfg.write_cycle_ticks == '0) begin
						nxt.phase = i2cebam_pkg::PH_IDLE;
						done = 1'b1;
					end
				end
				default: begin
					nxt.phase = i2cebam_pkg::PH_IDLE;
					nxt.scl = 1'b1;
					nxt.sda = 1'b1;
					nxt.tick_count = '0;
					done = 1'b1;
				end
			endcase
		end

		res.scl_level = nxt.scl;
		res.sda_release = nxt.sda;
		res.busy_res = (nxt.phase != i2cebam_pkg::PH_IDLE);
		res.done_res = done;
		res.read_byte = (done && nxt.is_read) ? nxt.shift_byte : 8'd0;
	end

endmodule
